[design/fptb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and codes for the bounding-box point fit block.
package fptb_pkg;

   // Default capacity of the point store
   localparam int MAX_POINTS_DEF = 64;

   // Coordinate and divider widths
   localparam int DATA_W  = 32;
   localparam int NUM_W   = 48;
   localparam int DEN_W   = 32;
   localparam int RATIO_W = 35;
   localparam int PADDR_W = 5;

   // Register map (word index)
   localparam logic [2:0] REG_TARGET_MIN_U  = 3'd0;
   localparam logic [2:0] REG_TARGET_MAX_U  = 3'd1;
   localparam logic [2:0] REG_TARGET_MIN_V  = 3'd2;
   localparam logic [2:0] REG_TARGET_MAX_V  = 3'd3;
   localparam logic [2:0] REG_UNIFORM_SCALE = 3'd4;

   // Q16.16 one, and the numerator of the ratio division (2^32)
   localparam logic signed [DATA_W-1:0] SCALE_ONE = 32'sd65536;
   localparam logic [NUM_W-1:0] RATIO_NUM = 48'h0001_0000_0000;
   // Stands for an unbounded ratio (zero scale); above every finite ratio
   localparam logic signed [RATIO_W-1:0] RATIO_INF = 35'sh2_0000_0000;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RD,
      ST_DIFF,
      ST_MUL,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      OP_SCALE_U,
      OP_SCALE_V,
      OP_RATIO_U,
      OP_RATIO_V
   } div_op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] tmin_u;
      logic signed [DATA_W-1:0] tmax_u;
      logic signed [DATA_W-1:0] tmin_v;
      logic signed [DATA_W-1:0] tmax_v;
      logic                     uniform;
   } csr_cfg_type;

   typedef struct packed {
      logic       point_accept;
      logic       div_start;
      div_op_type div_op;
      logic       div_store;
      logic       mem_rd;
      logic       diff_load;
      logic       mul_load;
      logic       out_load;
      logic       idx_next;
      logic       set_clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic uniform;
      logic out_free;
      logic idx_last;
   } dp_status_type;

endpackage

[design/fptb_csr.sv]
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module fptb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fptb_pkg::PADDR_W-1:0]     paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output fptb_pkg::csr_cfg_type            cfg
);
   import fptb_pkg::*;

   logic                     wr_en;
   logic [2:0]               reg_idx;
   logic signed [DATA_W-1:0] tmin_u_ff, tmin_u_in;
   logic signed [DATA_W-1:0] tmax_u_ff, tmax_u_in;
   logic signed [DATA_W-1:0] tmin_v_ff, tmin_v_in;
   logic signed [DATA_W-1:0] tmax_v_ff, tmax_v_in;
   logic                     uniform_ff, uniform_in;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[PADDR_W-1:2];
   assign pready  = 1'b1;

   // Decode the write
   always_comb begin
      tmin_u_in  = tmin_u_ff;
      tmax_u_in  = tmax_u_ff;
      tmin_v_in  = tmin_v_ff;
      tmax_v_in  = tmax_v_ff;
      uniform_in = uniform_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TARGET_MIN_U:  tmin_u_in  = pwdata;
            REG_TARGET_MAX_U:  tmax_u_in  = pwdata;
            REG_TARGET_MIN_V:  tmin_v_in  = pwdata;
            REG_TARGET_MAX_V:  tmax_v_in  = pwdata;
            REG_UNIFORM_SCALE: uniform_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_u_ff  <= '0;
         tmax_u_ff  <= SCALE_ONE;
         tmin_v_ff  <= '0;
         tmax_v_ff  <= SCALE_ONE;
         uniform_ff <= 1'b0;
      end else begin
         tmin_u_ff  <= tmin_u_in;
         tmax_u_ff  <= tmax_u_in;
         tmin_v_ff  <= tmin_v_in;
         tmax_v_ff  <= tmax_v_in;
         uniform_ff <= uniform_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_TARGET_MIN_U:  prdata = tmin_u_ff;
         REG_TARGET_MAX_U:  prdata = tmax_u_ff;
         REG_TARGET_MIN_V:  prdata = tmin_v_ff;
         REG_TARGET_MAX_V:  prdata = tmax_v_ff;
         REG_UNIFORM_SCALE: prdata = {31'd0, uniform_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.tmin_u  = tmin_u_ff;
   assign cfg.tmax_u  = tmax_u_ff;
   assign cfg.tmin_v  = tmin_v_ff;
   assign cfg.tmax_v  = tmax_v_ff;
   assign cfg.uniform = uniform_ff;

endmodule

[design/fptb_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module fptb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fptb_pkg::NUM_W-1:0]    num,
   input  logic [fptb_pkg::DEN_W-1:0]    den,
   output logic                          done,
   output logic [fptb_pkg::NUM_W-1:0]    quo
);
   import fptb_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   // One shift-subtract step per cycle
   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], work_ff[NUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[NUM_W-2:0], ge};
         rem_in  = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = work_ff;

endmodule

[design/fptb_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: point loading, the division phase and result emission.
module fptb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last_point,
   output logic                      req_ready,
   input  fptb_pkg::dp_status_type   status,
   output fptb_pkg::ctrl_cmd_type    cmd
);
   import fptb_pkg::*;

   ctrl_state_type state_ff, state_in;
   div_op_type     op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         op_ff    <= OP_SCALE_U;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.div_op = op_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready        = 1'b1;
            cmd.point_accept = req_valid;
            if (req_valid && req_last_point) begin
               op_in    = OP_SCALE_U;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               // Ratios are needed only for a shared scale
               if (op_ff == OP_RATIO_V || (op_ff == OP_SCALE_V && !status.uniform)) begin
                  state_in = ST_RD;
               end else begin
                  op_in    = div_op_type'(op_ff + 2'd1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.idx_last) begin
                  cmd.set_clear = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in     = ST_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

[design/fptb_dp.sv]
`timescale 1ns / 1ps
// Datapath: point store, bounding box, scales and the per-point transform.
module fptb_dp #(
   parameter int MAX_POINTS = fptb_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fptb_pkg::csr_cfg_type             cfg,
   input  fptb_pkg::ctrl_cmd_type            cmd,
   output fptb_pkg::dp_status_type           status,
   input  logic signed [fptb_pkg::DATA_W-1:0] req_in_u,
   input  logic signed [fptb_pkg::DATA_W-1:0] req_in_v,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [fptb_pkg::DATA_W-1:0] rsp_out_u,
   output logic signed [fptb_pkg::DATA_W-1:0] rsp_out_v,
   output logic                              rsp_last_result,
   output logic                              rsp_degenerate
);
   import fptb_pkg::*;

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] NEG_MAX = 32'sh8000_0000;

   // Saturate a quotient magnitude to a signed Q16.16 scale
   function automatic logic signed [DATA_W-1:0] sat_scale(input logic [NUM_W-1:0] q,
                                                          input logic neg);
      logic        big;
      logic [31:0] neg_q;
      big   = |q[NUM_W-1:31];
      neg_q = -q[31:0];
      if (neg) return big ? NEG_MAX : neg_q;
      return big ? POS_MAX : q[31:0];
   endfunction

   // Distance of a scale from one, as used for the shared-scale choice
   function automatic logic signed [RATIO_W-1:0] ratio_of(input logic signed [DATA_W-1:0] s,
                                                          input logic [NUM_W-1:0] q);
      logic signed [RATIO_W-1:0] mag;
      mag = {2'b00, q[32:0]};
      if (s >= SCALE_ONE) return {{(RATIO_W-DATA_W){s[DATA_W-1]}}, s};
      if (s == '0) return RATIO_INF;
      return s[DATA_W-1] ? -mag : mag;
   endfunction

   // Saturate a wide signed value to 32 bits
   function automatic logic [31:0] sat_word(input logic signed [65:0] x);
      logic fits;
      fits = (x[65:31] == {35{x[65]}});
      if (fits) return x[31:0];
      return x[65] ? NEG_MAX : POS_MAX;
   endfunction

   logic [63:0]               point_mem [MAX_POINTS];
   logic [63:0]               rd_data_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         rd_idx_ff, rd_idx_in;
   logic signed [DATA_W-1:0]  min_u_ff, min_u_in, max_u_ff, max_u_in;
   logic signed [DATA_W-1:0]  min_v_ff, min_v_in, max_v_ff, max_v_in;
   logic signed [DATA_W-1:0]  scale_u_ff, scale_u_in, scale_v_ff, scale_v_in;
   logic signed [RATIO_W-1:0] ratio_u_ff, ratio_u_in;
   logic                      degen_ff, degen_in;
   logic signed [32:0]        d_u_ff, d_v_ff;
   logic signed [64:0]        prod_u_ff, prod_v_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               out_u_ff, out_v_ff;
   logic                      out_last_ff, out_degen_ff;
   logic                      has_room, store_en;

   logic signed [32:0]        te_u, te_v, te_u_neg, te_v_neg;
   logic [31:0]               abs_te_u, abs_te_v, src_u, src_v, abs_su, abs_sv;
   logic [NUM_W-1:0]          div_num, div_quo;
   logic [DEN_W-1:0]          div_den;
   logic                      div_done;
   logic signed [RATIO_W-1:0] ratio_v;

   logic signed [32:0]        two_pu, two_pv;
   logic signed [33:0]        bsum_u, bsum_v, dfull_u, dfull_v, tsum_u, tsum_v;
   logic signed [65:0]        acc_u, acc_v, sh_u, sh_v;

   assign has_room = (count_ff < CNT_W'(MAX_POINTS));
   assign store_en = cmd.point_accept && has_room;

   // Store the point and read back for emission
   always_ff @(posedge clock) begin
      if (store_en) begin
         point_mem[count_ff[ADDR_W-1:0]] <= {req_in_v, req_in_u};
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= point_mem[rd_idx_ff];
      end
   end

   // Track count and bounding box; clear when the set closes
   always_comb begin
      count_in = count_ff;
      min_u_in = min_u_ff;
      max_u_in = max_u_ff;
      min_v_in = min_v_ff;
      max_v_in = max_v_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.set_clear) begin
         count_in  = '0;
         min_u_in  = POS_MAX;
         max_u_in  = NEG_MAX;
         min_v_in  = POS_MAX;
         max_v_in  = NEG_MAX;
         rd_idx_in = '0;
      end else begin
         if (store_en) begin
            count_in = count_ff + CNT_W'(1);
            if (req_in_u < min_u_ff) min_u_in = req_in_u;
            if (req_in_u > max_u_ff) max_u_in = req_in_u;
            if (req_in_v < min_v_ff) min_v_in = req_in_v;
            if (req_in_v > max_v_ff) max_v_in = req_in_v;
         end
         if (cmd.idx_next) rd_idx_in = rd_idx_ff + ADDR_W'(1);
      end
   end

   // Divider operands
   always_comb begin
      te_u     = 33'(cfg.tmax_u) - 33'(cfg.tmin_u);
      te_v     = 33'(cfg.tmax_v) - 33'(cfg.tmin_v);
      te_u_neg = -te_u;
      te_v_neg = -te_v;
      abs_te_u = te_u[32] ? te_u_neg[31:0] : te_u[31:0];
      abs_te_v = te_v[32] ? te_v_neg[31:0] : te_v[31:0];
      src_u    = max_u_ff - min_u_ff;
      src_v    = max_v_ff - min_v_ff;
      abs_su   = scale_u_ff[DATA_W-1] ? -scale_u_ff : scale_u_ff;
      abs_sv   = scale_v_ff[DATA_W-1] ? -scale_v_ff : scale_v_ff;
      case (cmd.div_op)
         OP_SCALE_U: begin
            div_num = {abs_te_u, 16'h0000};
            div_den = src_u;
         end
         OP_SCALE_V: begin
            div_num = {abs_te_v, 16'h0000};
            div_den = src_v;
         end
         OP_RATIO_U: begin
            div_num = RATIO_NUM;
            div_den = abs_su;
         end
         default: begin
            div_num = RATIO_NUM;
            div_den = abs_sv;
         end
      endcase
   end

   fptb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Latch scales and ratios; pick the shared scale on the last ratio
   always_comb begin
      scale_u_in = scale_u_ff;
      scale_v_in = scale_v_ff;
      ratio_u_in = ratio_u_ff;
      degen_in   = cmd.set_clear ? 1'b0 : degen_ff;
      ratio_v    = ratio_of(scale_v_ff, div_quo);
      if (cmd.div_store) begin
         case (cmd.div_op)
            OP_SCALE_U: begin
               if (src_u == '0) begin
                  scale_u_in = SCALE_ONE;
                  degen_in   = 1'b1;
               end else begin
                  scale_u_in = sat_scale(div_quo, te_u[32]);
               end
            end
            OP_SCALE_V: begin
               if (src_v == '0) begin
                  scale_v_in = SCALE_ONE;
                  degen_in   = 1'b1;
               end else begin
                  scale_v_in = sat_scale(div_quo, te_v[32]);
               end
            end
            OP_RATIO_U: ratio_u_in = ratio_of(scale_u_ff, div_quo);
            default: begin
               if (ratio_v > ratio_u_ff) scale_u_in = scale_v_ff;
               else                      scale_v_in = scale_u_ff;
            end
         endcase
      end
   end

   // Transform terms: centered offset, product, recentered sum
   always_comb begin
      two_pu  = {rd_data_ff[31:0], 1'b0};
      two_pv  = {rd_data_ff[63:32], 1'b0};
      bsum_u  = 34'(min_u_ff) + 34'(max_u_ff);
      bsum_v  = 34'(min_v_ff) + 34'(max_v_ff);
      dfull_u = 34'(two_pu) - bsum_u;
      dfull_v = 34'(two_pv) - bsum_v;
      tsum_u  = 34'(cfg.tmin_u) + 34'(cfg.tmax_u);
      tsum_v  = 34'(cfg.tmin_v) + 34'(cfg.tmax_v);
      acc_u   = 66'(prod_u_ff) + (66'(tsum_u) <<< 16);
      acc_v   = 66'(prod_v_ff) + (66'(tsum_v) <<< 16);
      sh_u    = acc_u >>> 17;
      sh_v    = acc_v >>> 17;
   end

   // Output register: load when empty or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         min_u_ff     <= POS_MAX;
         max_u_ff     <= NEG_MAX;
         min_v_ff     <= POS_MAX;
         max_v_ff     <= NEG_MAX;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         min_u_ff     <= min_u_in;
         max_u_ff     <= max_u_in;
         min_v_ff     <= min_v_in;
         max_v_ff     <= max_v_in;
         degen_ff     <= degen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_u_ff <= scale_u_in;
      scale_v_ff <= scale_v_in;
      ratio_u_ff <= ratio_u_in;
      if (cmd.diff_load) begin
         d_u_ff <= dfull_u[32:0];
         d_v_ff <= dfull_v[32:0];
      end
      if (cmd.mul_load) begin
         prod_u_ff <= d_u_ff * scale_u_ff;
         prod_v_ff <= d_v_ff * scale_v_ff;
      end
      if (cmd.out_load) begin
         out_u_ff     <= sat_word(sh_u);
         out_v_ff     <= sat_word(sh_v);
         out_last_ff  <= status.idx_last;
         out_degen_ff <= degen_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.uniform  = cfg.uniform;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.idx_last = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_u       = out_u_ff;
   assign rsp_out_v       = out_v_ff;
   assign rsp_last_result = out_last_ff;
   assign rsp_degenerate  = out_degen_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store capacity");

   a_read_written: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> (CNT_W'(rd_idx_ff) < count_ff))
      else $error("emission reads an entry outside the current set");

   a_clear_set: assert property (@(posedge clock) disable iff (reset)
      cmd.set_clear |=> (count_ff == '0 && !degen_ff && rd_idx_ff == '0))
      else $error("set not cleared after its last result");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_u_ff <= max_u_ff && min_v_ff <= max_v_ff))
      else $error("bounding box inverted while points are stored");

endmodule

[design/fit_points_to_box_2d.sv]
`timescale 1ns / 1ps
// Top level of the bounding-box point fit block.
// Usage:
//   Send a set of Q16.16 points on the req_ channel (valid/ready), one point per
//   request; the request with req_last_point high closes the set. Each point is
//   stored and the bounding box updated as it is accepted. Points beyond
//   MAX_POINTS are dropped. After the closing request the block runs a 48-step
//   restoring divider: two divisions for the per-axis scales, two more when
//   uniform_scale is set. It then emits one transformed point per stored point
//   on the rsp_ channel, in arrival order, each result going through store
//   read, offset, multiply and round/saturate, the last one marked.
//   req_ready is high only while points are being collected; a set's results are
//   all produced before the next set is taken, and the final result may still sit
//   in the output register while the next set starts loading.
//   A stalled receiver holds the current result and the emission sequence waits.
//   Reset clears the set and restores the target box to [0, 1.0] on both axes
//   with per-axis scaling. The user must write the registers over the APB-style
//   port only while the block is idle; the block itself does not enforce this.
module fit_points_to_box_2d #(
   parameter int MAX_POINTS = fptb_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fptb_pkg::DATA_W-1:0] req_in_u,
   input  logic signed [fptb_pkg::DATA_W-1:0] req_in_v,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fptb_pkg::DATA_W-1:0] rsp_out_u,
   output logic signed [fptb_pkg::DATA_W-1:0] rsp_out_v,
   output logic                               rsp_last_result,
   output logic                               rsp_degenerate,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fptb_pkg::PADDR_W-1:0]       paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import fptb_pkg::*;

   csr_cfg_type   cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   fptb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fptb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   fptb_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_in_u        (req_in_u),
      .req_in_v        (req_in_v),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_u       (rsp_out_u),
      .rsp_out_v       (rsp_out_v),
      .rsp_last_result (rsp_last_result),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule
